@@ src/bvs_pkg.sv @@
// Shared types and constants for the bounded vector store.
// No dependencies; every other file imports this package.
`default_nettype none

package bvs_pkg;

  // Store geometry: the depth sets the 4-bit index and 5-bit count fields.
  localparam int DEPTH          = 16;
  localparam int IDX_W          = $clog2(DEPTH);
  localparam int CNT_W          = $clog2(DEPTH + 1);
  localparam int DATA_WIDTH_DEF = 32;

  // Port field widths.
  localparam int FUNC_W   = 3;
  localparam int PORT_DW  = 32;
  localparam int STATUS_W = 2;

  // Command queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Operation codes.
  localparam logic [FUNC_W-1:0] OP_GET   = 3'd0;
  localparam logic [FUNC_W-1:0] OP_SET   = 3'd1;
  localparam logic [FUNC_W-1:0] OP_PUSH  = 3'd2;
  localparam logic [FUNC_W-1:0] OP_POP   = 3'd3;
  localparam logic [FUNC_W-1:0] OP_ERASE = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

  // Decoded operation, at most one bit set; none set for unused codes.
  typedef struct packed {
    logic is_get;
    logic is_set;
    logic is_push;
    logic is_pop;
    logic is_erase;
  } op_kind_t;

  // Command handed from front to back through the queue.
  typedef struct packed {
    op_kind_t             kind;
    logic [IDX_W-1:0]     index;
    logic [PORT_DW-1:0]   value;
  } cmd_t;

endpackage

`default_nettype wire

@@ src/bvs_ifs.sv @@
// Request and response channel interfaces of the bounded vector store.
// Depends on bvs_pkg for field widths.
`default_nettype none

interface bvs_req_if import bvs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [IDX_W-1:0]    index;
  logic [PORT_DW-1:0]  value;

  modport source (output valid, func, index, value, input ready);
  modport sink   (input valid, func, index, value, output ready);
endinterface

interface bvs_rsp_if import bvs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [PORT_DW-1:0]  read_data;
  logic [STATUS_W-1:0] status;
  logic [CNT_W-1:0]    element_count;
  logic                vec_empty;

  modport source (output valid, read_data, status, element_count, vec_empty, input ready);
  modport sink   (input valid, read_data, status, element_count, vec_empty, output ready);
endinterface

`default_nettype wire

@@ src/bvs_front.sv @@
// Front end: accepts requests and decodes the opcode into a command.
// Depends on bvs_pkg and bvs_req_if.
`default_nettype none

module bvs_front import bvs_pkg::*; (
  bvs_req_if.sink     req,
  output cmd_t        cmd,
  output logic        cmd_valid,
  input  logic        cmd_ready
);

  op_kind_t kind;

  always_comb begin
    kind = '0;
    unique case (req.func)
      OP_GET:   kind.is_get   = 1'b1;
      OP_SET:   kind.is_set   = 1'b1;
      OP_PUSH:  kind.is_push  = 1'b1;
      OP_POP:   kind.is_pop   = 1'b1;
      OP_ERASE: kind.is_erase = 1'b1;
      default:  kind = '0;  // unused codes run as no-ops
    endcase
  end

  assign cmd.kind  = kind;
  assign cmd.index = req.index;
  assign cmd.value = req.value;
  assign cmd_valid = req.valid;
  assign req.ready = cmd_ready;

endmodule

`default_nettype wire

@@ src/bvs_queue.sv @@
// Short command queue decoupling front and back.
// Depends on bvs_pkg. Ready depends on fill state only.
`default_nettype none

module bvs_queue import bvs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cmd_t push_cmd,
  input  logic push_valid,
  output logic push_ready,
  output cmd_t pop_cmd,
  output logic pop_valid,
  input  logic pop_ready
);

  cmd_t                   entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] fill;
  logic                   do_push;
  logic                   do_pop;

  assign push_ready = (fill != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/bvs_back.sv @@
// Back end: element cells, use count and the registered response.
// Depends on bvs_pkg and bvs_rsp_if.
`default_nettype none

module bvs_back import bvs_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      cmd,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  bvs_rsp_if.source rsp
);

  logic [DATA_WIDTH-1:0] cells     [DEPTH];
  logic [DATA_WIDTH-1:0] shift_src [DEPTH];
  logic [CNT_W-1:0]      used_count;
  logic [CNT_W-1:0]      used_count_next;
  logic [DATA_WIDTH-1:0] wdata;
  logic                  take;
  logic                  idx_ok;
  logic                  is_full;
  logic                  is_zero;
  logic                  do_push;
  logic                  do_set;
  logic                  do_erase;
  logic [STATUS_W-1:0]   status_next;
  logic [PORT_DW-1:0]    read_next;

  // Take a command whenever the response register is free or draining.
  assign cmd_ready = !rsp.valid || rsp.ready;
  assign take      = cmd_valid && cmd_ready;

  assign idx_ok   = {1'b0, cmd.index} < used_count;
  assign is_full  = (used_count == CNT_W'(DEPTH));
  assign is_zero  = (used_count == '0);
  assign wdata    = DATA_WIDTH'(cmd.value);
  assign do_set   = take && cmd.kind.is_set && idx_ok;
  assign do_push  = take && cmd.kind.is_push && !is_full;
  assign do_erase = take && cmd.kind.is_erase && idx_ok;

  // Neighbor feed for the erase shift; the top cell keeps its value.
  for (genvar g = 0; g < DEPTH; g++) begin : g_src
    if (g < DEPTH - 1) begin : g_mid
      assign shift_src[g] = cells[g+1];
    end else begin : g_top
      assign shift_src[g] = cells[g];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (do_set && (cmd.index == IDX_W'(i))) begin
        cells[i] <= wdata;
      end else if (do_push && (used_count == CNT_W'(i))) begin
        cells[i] <= wdata;
      end else if (do_erase && (IDX_W'(i) >= cmd.index)) begin
        cells[i] <= shift_src[i];
      end
    end
  end

  always_comb begin
    used_count_next = used_count;
    status_next     = ST_OK;
    read_next       = '0;
    if (cmd.kind.is_get) begin
      if (idx_ok) read_next   = PORT_DW'(cells[cmd.index]);
      else        status_next = ST_RANGE;
    end else if (cmd.kind.is_set) begin
      if (!idx_ok) status_next = ST_RANGE;
    end else if (cmd.kind.is_push) begin
      if (is_full) status_next     = ST_FULL;
      else         used_count_next = used_count + 1'b1;
    end else if (cmd.kind.is_pop) begin
      if (is_zero) status_next     = ST_EMPTY;
      else         used_count_next = used_count - 1'b1;
    end else if (cmd.kind.is_erase) begin
      if (idx_ok) used_count_next = used_count - 1'b1;
      else        status_next     = ST_RANGE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
      rsp.valid  <= 1'b0;
    end else begin
      if (take) begin
        used_count <= used_count_next;
        rsp.valid  <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp.read_data     <= read_next;
      rsp.status        <= status_next;
      rsp.element_count <= used_count_next;
      rsp.vec_empty     <= (used_count_next == '0);
    end
  end

endmodule

`default_nettype wire

@@ src/bounded_vector_store.sv @@
// Bounded vector store: top level joining front, command queue and back.
// Depends on bvs_pkg, bvs_ifs, bvs_front, bvs_queue, bvs_back.
//
// Usage:
//   req channel carries func, index and value; rsp channel returns
//   read_data, status, element_count and vec_empty. Both use valid/ready;
//   a transfer happens on a rising edge with valid and ready high.
//   Every request yields exactly one response, in request order.
// Path: a request is first registered in the command queue, then taken by
//   the back end, which registers its response in the response register.
// Throughput: one request per cycle sustained while rsp is taken. Every
//   operation, erase included, is done by the back end at once: the cells
//   at and above the index all load their upper neighbor together. The
//   two-entry command queue sets the slack between the channels.
// Stalls: when rsp is not taken the response register holds, the back end
//   stops, and the queue absorbs up to two more requests before req.ready
//   drops. req.ready depends on queue fill only, never on rsp.ready.
// Reset: synchronous, active high. Clears the element count, the queue and
//   the response valid. Element contents are not cleared; they are only
//   read below the count, where every entry was written by a push.
`default_nettype none

module bounded_vector_store import bvs_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  bvs_req_if.sink   req,
  bvs_rsp_if.source rsp
);

  // front -> queue
  cmd_t front_cmd;
  logic front_valid;
  logic front_ready;

  // queue -> back
  cmd_t back_cmd;
  logic back_valid;
  logic back_ready;

  // Decode opcodes at the input; no storage here.
  bvs_front u_front (
    .req       (req),
    .cmd       (front_cmd),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready)
  );

  // Decoupling queue; its ready is registered state.
  bvs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_cmd   (front_cmd),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_cmd    (back_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  // Element cells, count, and response register.
  bvs_back #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (back_cmd),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

@@ src/bvs_checker.sv @@
// Port-level checks for the bounded vector store, bound to the top level.
// Depends on bvs_pkg and bounded_vector_store.
`default_nettype none

module bvs_checker import bvs_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [PORT_DW-1:0]  rsp_read_data,
  input logic [STATUS_W-1:0] rsp_status,
  input logic [CNT_W-1:0]    rsp_element_count,
  input logic                rsp_vec_empty
);

  logic [2:0] pending;
  logic       req_xfer;
  logic       rsp_xfer;

  assign req_xfer = req_valid && req_ready;
  assign rsp_xfer = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 3'(req_xfer) - 3'(rsp_xfer);
    end
  end

  // A stalled response holds steady.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data) &&
      $stable(rsp_status) && $stable(rsp_element_count) && $stable(rsp_vec_empty))
    else $error("response changed while stalled");

  // Reset drops the response.
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

  // Full and empty reports agree with the count.
  a_status_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |->
      (rsp_status != ST_FULL || rsp_element_count == CNT_W'(DEPTH)) &&
      (rsp_status != ST_EMPTY || (rsp_element_count == '0 && rsp_vec_empty)))
    else $error("status disagrees with element count");

  // No response without an outstanding request.
  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    rsp_xfer |-> pending != '0)
    else $error("response transfer without a pending request");

endmodule

bind bounded_vector_store bvs_checker u_bvs_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_read_data     (rsp.read_data),
  .rsp_status        (rsp.status),
  .rsp_element_count (rsp.element_count),
  .rsp_vec_empty     (rsp.vec_empty)
);

`default_nettype wire
